FILE: hdl/mmp_pkg.sv
// Shared widths, defaults and constants of the masked mean pooling block.
`timescale 1ns / 1ps

package mmp_pkg;

	localparam int VALUE_W = 16;
	localparam int SUM_W = 26;
	localparam int IDX_W = 10;
	localparam int CFG_W = 11;

	localparam int MAX_DIM_DEF = 1024;
	localparam int MAX_TOKENS_DEF = 512;

	localparam logic [CFG_W-1:0] EMBED_DIM_RST = CFG_W'(384);

	localparam logic signed [SUM_W-1:0] SUM_MAX = {1'b0, {(SUM_W-1){1'b1}}};
	localparam logic signed [SUM_W-1:0] SUM_MIN = {1'b1, {(SUM_W-1){1'b0}}};
	localparam logic signed [SUM_W-1:0] POOL_MAX = SUM_W'(32767);
	localparam logic signed [SUM_W-1:0] POOL_MIN = -SUM_W'(32768);

endpackage

FILE: hdl/mmp_ifs.sv
// Channel interfaces of the masked mean pooling block.
`timescale 1ns / 1ps

interface mmp_elem_if import mmp_pkg::*; ();
	logic valid;
	logic ready;
	logic signed [VALUE_W-1:0] value;
	logic token_valid;
	logic final_token;

	modport source(output valid, value, token_valid, final_token, input ready);
	modport sink(input valid, value, token_valid, final_token, output ready);
endinterface

interface mmp_pool_if import mmp_pkg::*; ();
	logic valid;
	logic ready;
	logic signed [VALUE_W-1:0] pooled;
	logic [IDX_W-1:0] dim_index;
	logic last;

	modport source(output valid, pooled, dim_index, last, input ready);
	modport sink(input valid, pooled, dim_index, last, output ready);
endinterface

interface mmp_cfg_if import mmp_pkg::*; ();
	logic valid;
	logic ready;
	logic [CFG_W-1:0] embed_dim;

	modport source(output valid, embed_dim, input ready);
	modport sink(input valid, embed_dim, output ready);
endinterface

FILE: hdl/mmp_sum_mem.sv
// Accumulator memory with one write port and one registered read port.
`timescale 1ns / 1ps

module mmp_sum_mem import mmp_pkg::*; #(
	parameter int DEPTH = MAX_DIM_DEF,
	parameter int AW = 10
) (
	input  logic                    clk,
	input  logic                    we,
	input  logic [AW-1:0]           waddr,
	input  logic signed [SUM_W-1:0] wdata,
	input  logic [AW-1:0]           raddr,
	output logic signed [SUM_W-1:0] rdata
);

	logic signed [SUM_W-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata <= mem_q[raddr];
	end

endmodule

FILE: hdl/mmp_div.sv
// Restoring divider, one quotient bit per cycle, truncating toward zero.
`timescale 1ns / 1ps

module mmp_div import mmp_pkg::*; #(
	parameter int DVW = 10
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    start,
	input  logic signed [SUM_W-1:0] dividend,
	input  logic [DVW-1:0]          divisor,
	output logic                    busy,
	output logic                    done,
	output logic signed [SUM_W-1:0] quotient
);

	localparam int ITW = $clog2(SUM_W + 1);

	logic busy_q;
	logic done_q;
	logic [ITW-1:0] cnt_q;
	logic neg_q;
	logic [DVW-1:0] div_q;
	logic [DVW-1:0] rem_q;
	logic [SUM_W-1:0] quo_q;

	logic [DVW:0] rem_sh;
	logic [DVW:0] rem_nx;
	logic ge;

	always_comb begin
		rem_sh = {rem_q, quo_q[SUM_W-1]};
		ge = (rem_sh >= {1'b0, div_q});
		rem_nx = ge ? (rem_sh - {1'b0, div_q}) : rem_sh;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start && !busy_q) begin
				busy_q <= 1'b1;
				cnt_q <= ITW'(SUM_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - ITW'(1);
				if (cnt_q == ITW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start && !busy_q) begin
			neg_q <= dividend[SUM_W-1];
			quo_q <= dividend[SUM_W-1] ? SUM_W'(-dividend) : SUM_W'(dividend);
			div_q <= divisor;
			rem_q <= '0;
		end else if (busy_q) begin
			rem_q <= rem_nx[DVW-1:0];
			quo_q <= {quo_q[SUM_W-2:0], ge};
		end
	end

	assign busy = busy_q;
	assign done = done_q;
	assign quotient = neg_q ? -$signed(quo_q) : $signed(quo_q);

endmodule

FILE: hdl/masked_mean_pooling_top.sv
// Masked mean pooling: per-dimension accumulation and readout of token embeddings.
`timescale 1ns / 1ps
// Usage: embedding elements enter on the elem channel in token-major order, one
// element per transfer, with the token's mask bit and a final-token flag. Each
// element of an unmasked token is added into its dimension's accumulator in a
// memory with one read and one write port by a read, saturating add and write back.
// An element is taken in its transfer cycle and then updated in the memory
// read-modify-write cycle, during which elem.ready is low.
// An element of the final token also goes through a serial divider that forms the
// mean; its result is then registered and offered on the pool channel. The block
// takes no new element until that result has moved to the output register.
// The pool channel has an output register: a new element is taken while a result
// waits there; when the receiver stalls, a further result waits in the block and
// elem.ready stays low until the output register frees.
// The cfg channel always accepts and sets the embedding size, 384 after reset.
// After reset the block clears all MAX_DIM entries of the accumulator memory, one
// entry per cycle, and accepts no element during that pass.

module masked_mean_pooling_top import mmp_pkg::*; #(
	parameter int MAX_DIM = MAX_DIM_DEF,
	parameter int MAX_TOKENS = MAX_TOKENS_DEF
) (
	input  logic  clk,
	input  logic  arst_n,
	mmp_elem_if.sink   elem,
	mmp_pool_if.source pool,
	mmp_cfg_if.sink    cfg
);

	localparam int AW = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
	localparam int DW = $clog2(MAX_DIM + 1);
	localparam int CMPW = (DW > CFG_W) ? DW : CFG_W;
	localparam int CNTW = $clog2(MAX_TOKENS + 1);

	localparam logic [2:0] ST_CLEAR = 3'd0;
	localparam logic [2:0] ST_IDLE  = 3'd1;
	localparam logic [2:0] ST_READ  = 3'd2;
	localparam logic [2:0] ST_DIV   = 3'd3;
	localparam logic [2:0] ST_EMIT  = 3'd4;

	logic [2:0] state_q;
	logic [AW-1:0] clr_addr_q;
	logic [CFG_W-1:0] embed_dim_q;
	logic [AW-1:0] pos_q;
	logic [CNTW-1:0] count_q;
	logic held_mask_q;

	logic signed [VALUE_W-1:0] value_s1;
	logic mask_s1;
	logic final_s1;
	logic last_s1;
	logic [AW-1:0] pos_s1;
	logic [CNTW-1:0] count_s1;

	logic signed [VALUE_W-1:0] res_pooled_q;
	logic pool_valid_q;
	logic signed [VALUE_W-1:0] pool_pooled_q;
	logic [IDX_W-1:0] pool_idx_q;
	logic pool_last_q;

	logic accept;
	logic cur_mask;
	logic [CMPW-1:0] dim_c;
	logic is_last;
	logic [CNTW-1:0] count_eff;

	logic mem_we;
	logic [AW-1:0] mem_waddr;
	logic signed [SUM_W-1:0] mem_wdata;
	logic signed [SUM_W-1:0] mem_rdata;

	logic signed [SUM_W:0] sum_wide;
	logic signed [SUM_W-1:0] sum_sat;

	logic div_start;
	logic div_busy;
	logic div_done;
	logic signed [SUM_W-1:0] div_quo;
	logic [CNTW-1:0] divisor;
	logic signed [VALUE_W-1:0] quo_sat;

	logic [AW+IDX_W-1:0] pos_ext;
	logic out_free;
	logic emit_now;

	assign accept = elem.valid && elem.ready;
	assign elem.ready = (state_q == ST_IDLE);
	assign cfg.ready = 1'b1;

	always_comb begin
		if (embed_dim_q == '0) begin
			dim_c = CMPW'(1);
		end else if (CMPW'(embed_dim_q) > CMPW'(MAX_DIM)) begin
			dim_c = CMPW'(MAX_DIM);
		end else begin
			dim_c = CMPW'(embed_dim_q);
		end
		cur_mask = (pos_q == '0) ? elem.token_valid : held_mask_q;
		is_last = ((CMPW'(pos_q) + CMPW'(1)) >= dim_c);
		count_eff = (cur_mask && (count_q < CNTW'(MAX_TOKENS))) ?
			(count_q + CNTW'(1)) : count_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			embed_dim_q <= EMBED_DIM_RST;
		end else if (cfg.valid && cfg.ready) begin
			embed_dim_q <= cfg.embed_dim;
		end
	end

	always_comb begin
		sum_wide = $signed({mem_rdata[SUM_W-1], mem_rdata})
			+ $signed((SUM_W + 1)'(mask_s1 ? value_s1 : VALUE_W'(0)));
		if (sum_wide > (SUM_W + 1)'(SUM_MAX)) begin
			sum_sat = SUM_MAX;
		end else if (sum_wide < (SUM_W + 1)'(SUM_MIN)) begin
			sum_sat = SUM_MIN;
		end else begin
			sum_sat = sum_wide[SUM_W-1:0];
		end
	end

	always_comb begin
		mem_we = 1'b0;
		mem_waddr = pos_s1;
		mem_wdata = '0;
		unique case (state_q)
			ST_CLEAR: begin
				mem_we = 1'b1;
				mem_waddr = clr_addr_q;
			end
			ST_READ: begin
				mem_we = 1'b1;
				mem_wdata = final_s1 ? '0 : sum_sat;
			end
			default: begin
				mem_we = 1'b0;
			end
		endcase
	end

	mmp_sum_mem #(
		.DEPTH(MAX_DIM),
		.AW(AW)
	) u_sum_mem (
		.clk(clk),
		.we(mem_we),
		.waddr(mem_waddr),
		.wdata(mem_wdata),
		.raddr(pos_q),
		.rdata(mem_rdata)
	);

	assign div_start = (state_q == ST_READ) && final_s1;
	assign divisor = (count_s1 == '0) ? CNTW'(1) : count_s1;

	mmp_div #(
		.DVW(CNTW)
	) u_div (
		.clk(clk),
		.arst_n(arst_n),
		.start(div_start),
		.dividend(sum_sat),
		.divisor(divisor),
		.busy(div_busy),
		.done(div_done),
		.quotient(div_quo)
	);

	always_comb begin
		if (div_quo > POOL_MAX) begin
			quo_sat = VALUE_W'(POOL_MAX);
		end else if (div_quo < POOL_MIN) begin
			quo_sat = VALUE_W'(POOL_MIN);
		end else begin
			quo_sat = div_quo[VALUE_W-1:0];
		end
	end

	assign out_free = !pool_valid_q || pool.ready;
	assign emit_now = (state_q == ST_EMIT) && out_free;
	assign pos_ext = (AW + IDX_W)'(pos_s1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			clr_addr_q <= '0;
			pos_q <= '0;
			count_q <= '0;
			held_mask_q <= 1'b0;
			pool_valid_q <= 1'b0;
		end else begin
			pool_valid_q <= emit_now || (pool_valid_q && !pool.ready);
			unique case (state_q)
				ST_CLEAR: begin
					clr_addr_q <= clr_addr_q + AW'(1);
					if (clr_addr_q == AW'(MAX_DIM - 1)) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (accept) begin
						held_mask_q <= cur_mask;
						if (is_last) begin
							pos_q <= '0;
							count_q <= elem.final_token ? '0 : count_eff;
						end else begin
							pos_q <= pos_q + AW'(1);
						end
						state_q <= ST_READ;
					end
				end
				ST_READ: begin
					state_q <= final_s1 ? ST_DIV : ST_IDLE;
				end
				ST_DIV: begin
					if (div_done) begin
						state_q <= ST_EMIT;
					end
				end
				ST_EMIT: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			value_s1 <= elem.value;
			mask_s1 <= cur_mask;
			final_s1 <= elem.final_token;
			last_s1 <= is_last;
			pos_s1 <= pos_q;
			count_s1 <= count_eff;
		end
		if (div_done) begin
			res_pooled_q <= quo_sat;
		end
		if (emit_now) begin
			pool_pooled_q <= res_pooled_q;
			pool_idx_q <= pos_ext[IDX_W-1:0];
			pool_last_q <= last_s1;
		end
	end

	assign pool.valid = pool_valid_q;
	assign pool.pooled = pool_pooled_q;
	assign pool.dim_index = pool_idx_q;
	assign pool.last = pool_last_q;

	a_ready_not_div: assert property (@(posedge clk) disable iff (!arst_n)
		elem.ready |-> !div_busy)
		else $error("Element taken while the divider is busy.");

	a_accept_to_read: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> (state_q == ST_READ))
		else $error("Accepted element did not go to the memory update.");

	a_done_in_div: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> (state_q == ST_DIV))
		else $error("Divider finished outside the divide state.");

	a_write_phase: assert property (@(posedge clk) disable iff (!arst_n)
		mem_we |-> ((state_q == ST_READ) || (state_q == ST_CLEAR)))
		else $error("Accumulator memory written outside an update or clear.");

endmodule
